/* rtl/cpe_pkg.sv */
// Shared types, constants and helpers for the calibration polynomial evaluator.
`timescale 1ns / 1ps
package cpe_pkg;
	localparam int COEF_WORDS = 8;
	localparam int FRAC_BITS  = 16;
	localparam int WORD_W     = 32;
	localparam int CFG_W      = 64;
	localparam int CIDX_W     = $clog2(COEF_WORDS) + 1;
	localparam int TERMS_W    = 4;

	localparam int SQ_STEPS = (WORD_W + FRAC_BITS + 1) / 2;
	localparam int SQ_X_W   = 2 * SQ_STEPS;
	localparam int SQ_R_W   = SQ_STEPS + 3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_CLAMPED  = 3'd1;
	localparam logic [2:0] ST_ABOVE    = 3'd2;
	localparam logic [2:0] ST_TOO_MANY = 3'd3;
	localparam logic [2:0] ST_NEG_ROOT = 3'd4;

	localparam logic [3:0] REG_LEVEL_MIN = 4'd0;
	localparam logic [3:0] REG_LEVEL_MAX = 4'd1;
	localparam logic [3:0] REG_USE_ROOT  = 4'd2;
	localparam logic [3:0] REG_TERMS     = 4'd3;
	localparam logic [3:0] REG_COEF_01   = 4'd4;
	localparam logic [3:0] REG_COEF_23   = 4'd5;
	localparam logic [3:0] REG_COEF_45   = 4'd6;
	localparam logic [3:0] REG_COEF_67   = 4'd7;

	typedef logic [COEF_WORDS-1:0][WORD_W-1:0] coef_arr_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] v;
		logic [2:0]               status;
	} meta_t;

	typedef struct packed {
		logic [SQ_R_W-1:0]   rem;
		logic [SQ_STEPS-1:0] root;
		logic [SQ_X_W-1:0]   x;
	} sq_t;

	typedef struct packed {
		logic signed [63:0]       sum;
		logic signed [WORD_W-1:0] p;
	} acc_t;

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (x > hi)
			return WORD_W'(hi);
		else if (x < lo)
			return WORD_W'(lo);
		else
			return x[WORD_W-1:0];
	endfunction
endpackage

/* rtl/cpe_root_cell.sv */
// One digit step of the pipelined square root, with item tags riding alongside.
`timescale 1ns / 1ps
module cpe_root_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_vld,
	input  cpe_pkg::meta_t  in_meta,
	input  cpe_pkg::sq_t    in_sq,
	output logic            out_vld,
	output cpe_pkg::meta_t  out_meta,
	output cpe_pkg::sq_t    out_sq
);
	logic                          vld_q;
	cpe_pkg::meta_t                meta_q;
	cpe_pkg::sq_t                  sq_q;
	logic [cpe_pkg::SQ_R_W-1:0]    rem_sh;
	logic [cpe_pkg::SQ_R_W-1:0]    trial;
	cpe_pkg::sq_t                  sq_d;

	always_comb begin
		rem_sh = {in_sq.rem[cpe_pkg::SQ_R_W-3:0], in_sq.x[cpe_pkg::SQ_X_W-1 -: 2]};
		trial  = cpe_pkg::SQ_R_W'({in_sq.root, 2'b01});
		sq_d.x = {in_sq.x[cpe_pkg::SQ_X_W-3:0], 2'b00};
		if (rem_sh >= trial) begin
			sq_d.rem  = rem_sh - trial;
			sq_d.root = {in_sq.root[cpe_pkg::SQ_STEPS-2:0], 1'b1};
		end else begin
			sq_d.rem  = rem_sh;
			sq_d.root = {in_sq.root[cpe_pkg::SQ_STEPS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q <= in_meta;
			sq_q   <= sq_d;
		end
	end

	assign out_vld  = vld_q;
	assign out_meta = meta_q;
	assign out_sq   = sq_q;
endmodule

/* rtl/cpe_poly_cell.sv */
// One polynomial term: multiply, then accumulate and step the power.
`timescale 1ns / 1ps
module cpe_poly_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic [cpe_pkg::CIDX_W-1:0]        idx,
	input  logic                              root_on,
	input  logic [cpe_pkg::TERMS_W-1:0]       terms,
	input  cpe_pkg::coef_arr_t                coefs,
	input  logic                              in_vld,
	input  cpe_pkg::meta_t                    in_meta,
	input  cpe_pkg::acc_t                     in_acc,
	output logic                              out_vld,
	output cpe_pkg::meta_t                    out_meta,
	output cpe_pkg::acc_t                     out_acc
);
	logic [cpe_pkg::CIDX_W-1:0]        widx;
	logic signed [cpe_pkg::WORD_W-1:0] c;
	logic                              en;

	logic                              vld_s1;
	cpe_pkg::meta_t                    meta_s1;
	logic signed [63:0]                sum_s1;
	logic signed [63:0]                pc_s1;
	logic signed [63:0]                pv_s1;
	logic                              en_s1;

	logic                              vld_s2;
	cpe_pkg::meta_t                    meta_s2;
	cpe_pkg::acc_t                     acc_s2;
	logic signed [63:0]                term;

	always_comb begin
		widx = idx + (root_on ? cpe_pkg::CIDX_W'(2) : cpe_pkg::CIDX_W'(0));
		if (widx < cpe_pkg::CIDX_W'(cpe_pkg::COEF_WORDS))
			c = coefs[widx[cpe_pkg::CIDX_W-2:0]];
		else
			c = '0;
		en = 5'(idx) < 5'(terms);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign term = en_s1 ? (pc_s1 >>> cpe_pkg::FRAC_BITS) : 64'sd0;

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1    <= in_meta;
			sum_s1     <= in_acc.sum;
			pc_s1      <= 64'(c) * 64'(in_acc.p);
			pv_s1      <= 64'(in_acc.p) * 64'(in_meta.v);
			en_s1      <= en;
			meta_s2    <= meta_s1;
			acc_s2.sum <= sum_s1 + term;
			acc_s2.p   <= cpe_pkg::sat32(pv_s1 >>> cpe_pkg::FRAC_BITS);
		end
	end

	assign out_vld  = vld_s2;
	assign out_meta = meta_s2;
	assign out_acc  = acc_s2;
endmodule

/* rtl/calibration_polynomial_eval.sv */
// Top level of the calibration polynomial evaluator: config, range checks and cell chains.
`timescale 1ns / 1ps
// Accepts one wanted level per cycle and returns one control value and status per
// level, in order, after one front stage for clamping and checks, one square-root
// cell per result bit (24 at Q16.16), two stages for the root term, two stages per
// coefficient cell (8 cells) and the output register. Every stage moves together;
// a stalled output freezes the whole chain and holds in_ready low.
// Write configuration only while no request is in flight.
module calibration_polynomial_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  wanted_level,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  control_value,
	output logic [2:0]          status
);
	localparam int NS = cpe_pkg::SQ_STEPS;
	localparam int NP = cpe_pkg::COEF_WORDS;

	logic signed [31:0]               level_min_q;
	logic signed [31:0]               level_max_q;
	logic                             use_root_q;
	logic [cpe_pkg::TERMS_W-1:0]      terms_q;
	cpe_pkg::coef_arr_t               coef_q;

	logic                             adv;
	logic                             out_valid_q;
	logic signed [31:0]               ctl_q;
	logic [2:0]                       status_q;

	logic signed [31:0]               vc;
	logic [2:0]                       st;
	logic signed [32:0]               arg;
	logic [4:0]                       need;

	logic                             vld_s1;
	cpe_pkg::meta_t                   meta_s1;
	cpe_pkg::sq_t                     sq_s1;

	logic                             sq_vld  [NS+1];
	cpe_pkg::meta_t                   sq_meta [NS+1];
	cpe_pkg::sq_t                     sq_st   [NS+1];

	logic                             vld_m1;
	cpe_pkg::meta_t                   meta_m1;
	logic signed [63:0]               prod_m1;

	logic                             pl_vld  [NP+1];
	cpe_pkg::meta_t                   pl_meta [NP+1];
	cpe_pkg::acc_t                    pl_acc  [NP+1];

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_min_q <= '0;
			level_max_q <= '0;
			use_root_q  <= 1'b0;
			terms_q     <= '0;
			coef_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpe_pkg::REG_LEVEL_MIN: level_min_q <= cfg_data[31:0];
				cpe_pkg::REG_LEVEL_MAX: level_max_q <= cfg_data[31:0];
				cpe_pkg::REG_USE_ROOT:  use_root_q  <= cfg_data[0];
				cpe_pkg::REG_TERMS:     terms_q     <= cfg_data[3:0];
				cpe_pkg::REG_COEF_01: begin
					coef_q[0] <= cfg_data[31:0];
					coef_q[1] <= cfg_data[63:32];
				end
				cpe_pkg::REG_COEF_23: begin
					coef_q[2] <= cfg_data[31:0];
					coef_q[3] <= cfg_data[63:32];
				end
				cpe_pkg::REG_COEF_45: begin
					coef_q[4] <= cfg_data[31:0];
					coef_q[5] <= cfg_data[63:32];
				end
				cpe_pkg::REG_COEF_67: begin
					coef_q[6] <= cfg_data[31:0];
					coef_q[7] <= cfg_data[63:32];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (wanted_level < level_min_q) begin
			vc = level_min_q;
			st = cpe_pkg::ST_CLAMPED;
		end else begin
			vc = wanted_level;
			st = cpe_pkg::ST_OK;
		end
		arg  = 33'(vc) + 33'($signed(coef_q[1]));
		need = 5'(terms_q) + (use_root_q ? 5'd2 : 5'd0);
		if (vc > level_max_q)
			st = cpe_pkg::ST_ABOVE;
		else if (need > 5'(NP))
			st = cpe_pkg::ST_TOO_MANY;
		else if (use_root_q && arg[32])
			st = cpe_pkg::ST_NEG_ROOT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.v      <= vc;
			meta_s1.status <= st;
			sq_s1.rem      <= '0;
			sq_s1.root     <= '0;
			sq_s1.x        <= cpe_pkg::SQ_X_W'({arg[31:0], {cpe_pkg::FRAC_BITS{1'b0}}});
		end
	end

	assign sq_vld[0]  = vld_s1;
	assign sq_meta[0] = meta_s1;
	assign sq_st[0]   = sq_s1;

	for (genvar i = 0; i < NS; i++) begin : g_root
		cpe_root_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_vld   (sq_vld[i]),
			.in_meta  (sq_meta[i]),
			.in_sq    (sq_st[i]),
			.out_vld  (sq_vld[i+1]),
			.out_meta (sq_meta[i+1]),
			.out_sq   (sq_st[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1    <= 1'b0;
			pl_vld[0] <= 1'b0;
		end else if (adv) begin
			vld_m1    <= sq_vld[NS];
			pl_vld[0] <= vld_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_m1        <= sq_meta[NS];
			prod_m1        <= 64'($signed(coef_q[0]))
				* 64'($signed({1'b0, sq_st[NS].root}));
			pl_meta[0]     <= meta_m1;
			pl_acc[0].sum  <= use_root_q ? (prod_m1 >>> cpe_pkg::FRAC_BITS) : 64'sd0;
			pl_acc[0].p    <= 32'sd1 <<< cpe_pkg::FRAC_BITS;
		end
	end

	for (genvar k = 0; k < NP; k++) begin : g_poly
		cpe_poly_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.idx      (cpe_pkg::CIDX_W'(k)),
			.root_on  (use_root_q),
			.terms    (terms_q),
			.coefs    (coef_q),
			.in_vld   (pl_vld[k]),
			.in_meta  (pl_meta[k]),
			.in_acc   (pl_acc[k]),
			.out_vld  (pl_vld[k+1]),
			.out_meta (pl_meta[k+1]),
			.out_acc  (pl_acc[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= pl_vld[NP];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= pl_meta[NP].status;
			if (pl_meta[NP].status == cpe_pkg::ST_OK
				|| pl_meta[NP].status == cpe_pkg::ST_CLAMPED)
				ctl_q <= cpe_pkg::sat32(pl_acc[NP].sum);
			else
				ctl_q <= '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign control_value = ctl_q;
	assign status        = status_q;
endmodule
